// ===== rtl/lscu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lscu_pkg
// types, command codes and reply codes shared by the serial command unit
// ----------------------------------------------------------------------------
package lscu_pkg;

	localparam int MAX_DIGITS_DEF = 5;
	localparam int FRAME_W        = 17;
	localparam int CUR_W          = 16;
	localparam int MAX_RESULTS    = 3;

	// host command bytes
	localparam logic [7:0] CMD_PLAY     = 8'h25;
	localparam logic [7:0] CMD_PAUSE    = 8'h29;
	localparam logic [7:0] CMD_SEARCH   = 8'h2B;
	localparam logic [7:0] CMD_STOP     = 8'h2F;
	localparam logic [7:0] CMD_ENTER    = 8'h41;
	localparam logic [7:0] CMD_SKIP     = 8'h46;
	localparam logic [7:0] CMD_FC_ON    = 8'h4C;
	localparam logic [7:0] CMD_FC_OFF   = 8'h4D;
	localparam logic [7:0] CMD_RESET    = 8'h53;
	localparam logic [7:0] CMD_CLEAR    = 8'h68;
	localparam logic [7:0] CMD_REPORT   = 8'h6B;
	localparam logic [7:0] CMD_UNKNOWN  = 8'h6E;
	localparam logic [7:0] DIGIT_ZERO   = 8'h30;
	localparam logic [7:0] DIGIT_NINE   = 8'h39;

	// reply bytes
	localparam logic [7:0] ACK_PLAY     = 8'hA5;
	localparam logic [7:0] ACK_PAUSE    = 8'hA9;
	localparam logic [7:0] ACK_STOP     = 8'hAF;
	localparam logic [7:0] ACK_FC_ON    = 8'hCC;
	localparam logic [7:0] ACK_FC_OFF   = 8'hCD;
	localparam logic [7:0] ACK_RESET    = 8'hD3;
	localparam logic [7:0] ACK_CLEAR    = 8'hE8;
	localparam logic [7:0] ACK_REPORT   = 8'h6B;
	localparam logic [7:0] ACK_UNKNOWN  = 8'hEE;
	localparam logic [7:0] ACK_ENTER    = 8'h41;
	localparam logic [7:0] ACK_FOUND    = 8'hB0;
	localparam logic [7:0] ACK_SKIPPED  = 8'hC6;

	// item source
	localparam logic CMD_HOST = 1'b0;
	localparam logic CMD_POLL = 1'b1;

	// result kinds
	localparam logic KIND_HOST   = 1'b0;
	localparam logic KIND_PLAYER = 1'b1;

	// player status
	localparam logic [1:0] STATUS_PAUSED    = 2'd0;
	localparam logic [1:0] STATUS_SEARCHING = 2'd1;

	typedef enum logic [2:0] {
		OP_PLAY   = 3'd0,
		OP_PAUSE  = 3'd1,
		OP_SEARCH = 3'd2,
		OP_SKIP   = 3'd3,
		OP_FAIL   = 3'd4
	} player_op_t;

	typedef enum logic [1:0] {
		MODE_NONE   = 2'd0,
		MODE_SEARCH = 2'd1,
		MODE_SKIP   = 2'd2
	} mode_t;

	typedef struct packed {
		logic               kind;
		logic [7:0]         byte_val;
		player_op_t         op;
		logic [FRAME_W-1:0] target;
	} result_t;

	typedef struct packed {
		result_t [MAX_RESULTS-1:0] res;
		logic [1:0]                cnt;
	} decode_t;

	function automatic result_t host_res(input logic [7:0] b);
		result_t r;
		r.kind     = KIND_HOST;
		r.byte_val = b;
		r.op       = OP_PLAY;
		r.target   = '0;
		return r;
	endfunction

	function automatic result_t player_res(input player_op_t op,
		input logic [FRAME_W-1:0] tgt);
		result_t r;
		r.kind     = KIND_PLAYER;
		r.byte_val = 8'h00;
		r.op       = op;
		r.target   = tgt;
		return r;
	endfunction

endpackage

// ===== rtl/laserdisc_serial_command_unit_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// laserdisc_serial_command_unit_core
// serial command unit: host bytes and player polls in, replies and commands out
// ----------------------------------------------------------------------------
// input channel (in_valid/in_ready) carries one host byte or one player poll
// per transaction; output channel (out_valid/out_ready) carries one result per
// transaction, with last set on the final result of an input item.
// an accepted item is decoded in the same cycle and its zero to three results
// are written into the result register; the first is offered on the next
// cycle and the rest follow one per transaction. throughput: one item per
// cycle for items with at most one result while each result is taken; an
// item with n results holds the input until its last result is taken at the single result port.
// in_ready is high when the result register is empty or its last result is
// being taken in the same cycle; a stalled receiver therefore stalls the input.
// reset clears mode, search flag, digit count, accumulated frame and the
// result count of the result register; no results are pending after reset.
// ----------------------------------------------------------------------------
module laserdisc_serial_command_unit_core #(
	parameter int MAX_DIGITS = lscu_pkg::MAX_DIGITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         cmd,
	input  logic [7:0]                   host_byte,
	input  logic [1:0]                   player_status,
	input  logic [lscu_pkg::CUR_W-1:0]   current_frame,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         result_kind,
	output logic [7:0]                   response_byte,
	output logic [2:0]                   player_op,
	output logic [lscu_pkg::FRAME_W-1:0] target_frame,
	output logic                         last
);
	import lscu_pkg::*;

	decode_t dec;
	result_t head;
	logic    accept;

	assign accept = in_valid && in_ready;

	lscu_decode #(
		.MAX_DIGITS(MAX_DIGITS)
	) u_decode (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.cmd           (cmd),
		.host_byte     (host_byte),
		.player_status (player_status),
		.current_frame (current_frame),
		.dec           (dec)
	);

	lscu_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept),
		.dec       (dec),
		.can_load  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head),
		.last      (last)
	);

	assign result_kind   = head.kind;
	assign response_byte = head.byte_val;
	assign player_op     = head.op;
	assign target_frame  = head.target;

endmodule

// ===== rtl/lscu_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lscu_decode
// decodes one item against the mode, search and digit state, and updates it
// ----------------------------------------------------------------------------
module lscu_decode #(
	parameter int MAX_DIGITS = lscu_pkg::MAX_DIGITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  logic                       cmd,
	input  logic [7:0]                 host_byte,
	input  logic [1:0]                 player_status,
	input  logic [lscu_pkg::CUR_W-1:0] current_frame,
	output lscu_pkg::decode_t          dec
);
	import lscu_pkg::*;

	mode_t              mode_q, mode_d;
	logic               busy_q, busy_d;
	logic [2:0]         count_q, count_d;
	logic [FRAME_W-1:0] frame_q, frame_d;
	logic [FRAME_W-1:0] frame_acc;

	assign frame_acc = (frame_q << 3) + (frame_q << 1) + FRAME_W'(host_byte[3:0]);

	always_comb begin
		mode_d  = mode_q;
		busy_d  = busy_q;
		count_d = count_q;
		frame_d = frame_q;
		dec     = '0;
		if (cmd == CMD_POLL) begin
			if (busy_q) begin
				if (player_status == STATUS_PAUSED) begin
					dec.res[0] = host_res(ACK_ENTER);
					dec.res[1] = host_res(ACK_FOUND);
					dec.cnt    = 2'd2;
					busy_d     = 1'b0;
				end else if (player_status != STATUS_SEARCHING) begin
					dec.res[0] = player_res(OP_FAIL, '0);
					dec.cnt    = 2'd1;
					busy_d     = 1'b0;
				end
			end
		end else begin
			case (host_byte) inside
				[DIGIT_ZERO:DIGIT_NINE]: begin
					if (count_q < 3'(MAX_DIGITS)) begin
						frame_d = frame_acc;
						count_d = count_q + 3'd1;
					end
				end
				CMD_PLAY: begin
					dec.res[0] = player_res(OP_PLAY, '0);
					dec.res[1] = host_res(ACK_PLAY);
					dec.cnt    = 2'd2;
				end
				CMD_PAUSE: begin
					dec.res[0] = player_res(OP_PAUSE, '0);
					dec.res[1] = host_res(ACK_PAUSE);
					dec.cnt    = 2'd2;
				end
				CMD_RESET: begin
					dec.res[0] = player_res(OP_PLAY, '0);
					dec.res[1] = host_res(ACK_RESET);
					dec.cnt    = 2'd2;
				end
				CMD_SEARCH: mode_d = MODE_SEARCH;
				CMD_SKIP:   mode_d = MODE_SKIP;
				CMD_STOP: begin
					dec.res[0] = host_res(ACK_STOP);
					dec.cnt    = 2'd1;
				end
				CMD_FC_ON: begin
					dec.res[0] = host_res(ACK_FC_ON);
					dec.cnt    = 2'd1;
				end
				CMD_FC_OFF: begin
					dec.res[0] = host_res(ACK_FC_OFF);
					dec.cnt    = 2'd1;
				end
				CMD_CLEAR: begin
					dec.res[0] = host_res(ACK_CLEAR);
					dec.cnt    = 2'd1;
				end
				CMD_UNKNOWN: begin
					dec.res[0] = host_res(ACK_UNKNOWN);
					dec.cnt    = 2'd1;
				end
				CMD_REPORT: begin
					dec.res[0] = host_res(ACK_REPORT);
					dec.res[1] = host_res(current_frame[15:8]);
					dec.res[2] = host_res(current_frame[7:0]);
					dec.cnt    = 2'd3;
				end
				CMD_ENTER: begin
					mode_d = MODE_NONE;
					if (mode_q == MODE_SEARCH) begin
						if (!busy_q) begin
							dec.res[0] = player_res(OP_SEARCH, frame_q);
							dec.cnt    = 2'd1;
							busy_d     = 1'b1;
						end
						count_d = '0;
						frame_d = '0;
					end else if (mode_q == MODE_SKIP) begin
						dec.res[0] = player_res(OP_SKIP, {1'b0, frame_q[15:0]});
						dec.res[1] = host_res(ACK_ENTER);
						dec.res[2] = host_res(ACK_SKIPPED);
						dec.cnt    = 2'd3;
						count_d    = '0;
						frame_d    = '0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_NONE;
			busy_q  <= 1'b0;
			count_q <= '0;
			frame_q <= '0;
		end else if (accept) begin
			mode_q  <= mode_d;
			busy_q  <= busy_d;
			count_q <= count_d;
			frame_q <= frame_d;
		end
	end

endmodule

// ===== rtl/lscu_outbuf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lscu_outbuf
// result register of up to three results, handed out one per transaction
// ----------------------------------------------------------------------------
module lscu_outbuf (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       load,
	input  lscu_pkg::decode_t          dec,
	output logic                       can_load,
	output logic                       out_valid,
	input  logic                       out_ready,
	output lscu_pkg::result_t          head,
	output logic                       last
);
	import lscu_pkg::*;

	result_t [MAX_RESULTS-1:0] slot_q;
	logic [1:0]                rem_q;
	logic                      take;

	assign out_valid = (rem_q != 2'd0);
	assign take      = out_valid && out_ready;
	assign last      = (rem_q == 2'd1);
	assign can_load  = (rem_q == 2'd0) || (last && out_ready);
	assign head      = slot_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (load) begin
			rem_q <= dec.cnt;
		end else if (take) begin
			rem_q <= rem_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slot_q <= dec.res;
		end else if (take) begin
			slot_q[0] <= slot_q[1];
			slot_q[1] <= slot_q[2];
		end
	end

endmodule

// ===== rtl/lscu_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lscu_checker
// port-level checks of the serial command unit, bound to the top level
// ----------------------------------------------------------------------------
module lscu_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic                         result_kind,
	input logic [7:0]                   response_byte,
	input logic [2:0]                   player_op,
	input logic [lscu_pkg::FRAME_W-1:0] target_frame,
	input logic                         last
);
	import lscu_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_kind)
			&& $stable(response_byte) && $stable(player_op)
			&& $stable(target_frame) && $stable(last))
		else $error("stalled result changed");

	// no new transaction while more than one result of the previous item remains
	a_in_block: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> !in_ready)
		else $error("input accepted with results pending");

	a_host_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_HOST |-> player_op == OP_PLAY
			&& target_frame == '0)
		else $error("host reply carries player fields");

	a_player_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_PLAYER |-> response_byte == 8'h00
			&& (player_op == OP_SEARCH || player_op == OP_SKIP || target_frame == '0)
			&& (player_op != OP_SKIP || !target_frame[FRAME_W-1]))
		else $error("player command fields out of range");

endmodule

bind laserdisc_serial_command_unit_core lscu_checker u_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.result_kind   (result_kind),
	.response_byte (response_byte),
	.player_op     (player_op),
	.target_frame  (target_frame),
	.last          (last)
);
